// ===== rtl/iod_pkg.sv =====
// Package for the impulse onset detector: shared widths, defaults and codes.
// Used by iod_divider and impulse_onset_detector; depends on nothing.
package iod_pkg;

    // default widths
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEFF_BITS_DEF  = 16;

    // datapath widths
    localparam int AVG_W  = 24;  // averages, Q.8 sample units / Q8.16 level
    localparam int ACC_W  = 56;  // serial multiplier accumulator
    localparam int MULB_W = 25;  // serial multiplier operand (LSB first)
    localparam int DVD_W  = 56;  // divider dividend / quotient
    localparam int DVS_W  = 32;  // divider divisor
    localparam int REG_W  = 16;  // configuration register width
    localparam int IDX_W  = 4;   // configuration index width

    localparam logic [AVG_W-1:0] MAX24 = '1;

    // configuration register indexes
    localparam logic [IDX_W-1:0] IDX_FLOOR    = 4'd0;
    localparam logic [IDX_W-1:0] IDX_FAST     = 4'd1;
    localparam logic [IDX_W-1:0] IDX_SLOW     = 4'd2;
    localparam logic [IDX_W-1:0] IDX_LEVEL    = 4'd3;
    localparam logic [IDX_W-1:0] IDX_ON_THR   = 4'd4;
    localparam logic [IDX_W-1:0] IDX_OFF_THR  = 4'd5;
    localparam logic [IDX_W-1:0] IDX_BULGE    = 4'd6;
    localparam logic [IDX_W-1:0] IDX_FULL     = 4'd7;

    // reset values of the registers
    localparam logic [REG_W-1:0] RST_FAST    = 16'd49152;
    localparam logic [REG_W-1:0] RST_SLOW    = 16'd52429;
    localparam logic [REG_W-1:0] RST_LEVEL   = 16'd62259;
    localparam logic [REG_W-1:0] RST_ON_THR  = 16'd41;
    localparam logic [REG_W-1:0] RST_OFF_THR = 16'd4;
    localparam logic [REG_W-1:0] RST_BULGE   = 16'd19661;
    localparam logic [REG_W-1:0] RST_FULL    = 16'd8000;

    // detector phase codes
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_ONSET   = 2'd1;
    localparam logic [1:0] PH_ON      = 2'd2;
    localparam logic [1:0] PH_RELEASE = 2'd3;

endpackage

// ===== rtl/iod_divider.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on iod_pkg for its widths.
module iod_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [iod_pkg::DVD_W-1:0] dividend,
    input  logic [iod_pkg::DVS_W-1:0] divisor,
    output logic                      done,
    output logic [iod_pkg::DVD_W-1:0] quotient
);
    import iod_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W:0]       rem_reg, rem_next;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       diff;

    // one restoring step
    always_comb begin
        trial     = {rem_reg[DVS_W-1:0], dvd_reg[DVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff;
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ===== rtl/impulse_onset_detector.sv =====
// Top level of the impulse onset detector: sequencer, serial multiplier, state.
// Depends on iod_pkg and iod_divider.
//
// One sample word in, one result word out. An item runs through a bit-serial
// shift-add multiplier (one multiplier bit per cycle) and a 56-step restoring
// divider, one item at a time. Each of the three averages runs through the
// multiplier, as does the knee product bulge_ratio * full_scale. When the
// fast/slow difference is nonzero and within full scale, the bulge curve adds
// three divisions and a further product; otherwise the curve is zero. The
// sequencer is idle again as the result word is loaded, so the next sample is
// taken in the cycle after at the earliest. A new sample is taken whenever the
// sequencer is idle, even while the previous result waits on m_tready.
module impulse_onset_detector #(
    parameter int SAMPLE_BITS = iod_pkg::SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = iod_pkg::COEFF_BITS_DEF,
    parameter int S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [iod_pkg::IDX_W-1:0]   cfg_index,
    input  logic [iod_pkg::REG_W-1:0]   cfg_data,
    // sample input
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [S_TDATA_W-1:0]        s_tdata,   // sample
    // result output
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata    // level, detector_state, onset, release_res
);
    import iod_pkg::*;

    localparam int XW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int CNT_W = $clog2(MULB_W + 1);
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (COEFF_BITS - 1);
    localparam logic [COEFF_BITS:0] ONE = (COEFF_BITS+1)'(1) << COEFF_BITS;

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_F1   = 4'd1;
    localparam logic [3:0] ST_F2   = 4'd2;
    localparam logic [3:0] ST_S1   = 4'd3;
    localparam logic [3:0] ST_S2   = 4'd4;
    localparam logic [3:0] ST_SC   = 4'd5;
    localparam logic [3:0] ST_DA   = 4'd6;
    localparam logic [3:0] ST_DB   = 4'd7;
    localparam logic [3:0] ST_PM   = 4'd8;
    localparam logic [3:0] ST_DC   = 4'd9;
    localparam logic [3:0] ST_L1   = 4'd10;
    localparam logic [3:0] ST_L2   = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;

    // configuration registers
    logic [REG_W-1:0]       floor_reg, on_thr_reg, off_thr_reg, bulge_reg, full_reg;
    logic [COEFF_BITS-1:0]  fast_c_reg, slow_c_reg, level_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg   <= '0;
            fast_c_reg  <= COEFF_BITS'(RST_FAST);
            slow_c_reg  <= COEFF_BITS'(RST_SLOW);
            level_c_reg <= COEFF_BITS'(RST_LEVEL);
            on_thr_reg  <= RST_ON_THR;
            off_thr_reg <= RST_OFF_THR;
            bulge_reg   <= RST_BULGE;
            full_reg    <= RST_FULL;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                IDX_FLOOR:   floor_reg   <= cfg_data;
                IDX_FAST:    fast_c_reg  <= COEFF_BITS'(cfg_data);
                IDX_SLOW:    slow_c_reg  <= COEFF_BITS'(cfg_data);
                IDX_LEVEL:   level_c_reg <= COEFF_BITS'(cfg_data);
                IDX_ON_THR:  on_thr_reg  <= cfg_data;
                IDX_OFF_THR: off_thr_reg <= cfg_data;
                IDX_BULGE:   bulge_reg   <= cfg_data;
                IDX_FULL:    full_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // state and datapath registers
    logic [3:0]         st_reg, st_next;
    logic [AVG_W-1:0]   fast_reg, fast_next;
    logic [AVG_W-1:0]   slow_reg, slow_next;
    logic [AVG_W-1:0]   lavg_reg, lavg_next;
    logic [1:0]         phase_reg, phase_next;
    logic [AVG_W-1:0]   x_reg, x_next;       // smoothing input, then curve output
    logic [AVG_W-1:0]   d_reg, d_next;
    logic [AVG_W-1:0]   s_reg, s_next;
    logic [MULB_W-1:0]  a_reg, a_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]   mc_reg, mc_next;
    logic [MULB_W-1:0]  mb_reg, mb_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               mv_reg, mv_next;
    logic [23:0]        mdata_reg, mdata_next;

    // divider hookup
    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic               div_done;
    logic [DVD_W-1:0]   div_q;

    iod_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // combinational helpers
    logic [XW-1:0]      smp_w, floor_w, xdiff;
    logic [AVG_W-1:0]   x_in;
    logic [ACC_W-1:0]   acc_step;
    logic               mul_last;
    logic [ACC_W-1:0]   sm_shift;
    logic [AVG_W-1:0]   sm_res;
    logic [AVG_W-1:0]   p_val;
    logic [MULB_W-1:0]  ab_diff;
    logic [29:0]        m_val;
    logic [19:0]        lvl_raw;
    logic [15:0]        lvl;

    always_comb begin
        smp_w    = XW'(s_tdata[SAMPLE_BITS-1:0]);
        floor_w  = XW'(floor_reg);
        xdiff    = (smp_w > floor_w) ? smp_w - floor_w : '0;
        x_in     = (xdiff > XW'(16'hFFFF)) ? MAX24 : {xdiff[15:0], 8'h00};
        acc_step = acc_reg + (mb_reg[0] ? mc_reg : '0);
        mul_last = (cnt_reg == CNT_W'(1));
        sm_shift = acc_step >> COEFF_BITS;
        sm_res   = (|sm_shift[ACC_W-1:AVG_W]) ? MAX24 : sm_shift[AVG_W-1:0];
        p_val    = {full_reg, 8'h00};
        ab_diff  = a_reg - div_q[MULB_W-1:0];
        m_val    = {2'b00, s_reg, 4'h0} + {4'h0, s_reg, 2'b00} + {5'h00, p_val, 1'b0};
        lvl_raw  = lavg_reg[AVG_W-1:4];
        lvl      = (|lvl_raw[19:16]) ? 16'hFFFF : lvl_raw[15:0];
    end

    // sequencer
    always_comb begin
        st_next    = st_reg;
        fast_next  = fast_reg;
        slow_next  = slow_reg;
        lavg_next  = lavg_reg;
        phase_next = phase_reg;
        x_next     = x_reg;
        d_next     = d_reg;
        s_next     = s_reg;
        a_next     = a_reg;
        acc_next   = acc_reg;
        mc_next    = mc_reg;
        mb_next    = mb_reg;
        cnt_next   = cnt_reg;
        mv_next    = mv_reg && !m_tready;
        mdata_next = mdata_reg;
        div_start  = 1'b0;
        div_dvd    = '0;
        div_dvs    = '0;

        // serial multiplier step, LSB first
        if (st_reg == ST_F1 || st_reg == ST_F2 || st_reg == ST_S1 || st_reg == ST_S2 ||
            st_reg == ST_SC || st_reg == ST_PM || st_reg == ST_L1 || st_reg == ST_L2) begin
            acc_next = acc_step;
            mc_next  = {mc_reg[ACC_W-2:0], 1'b0};
            mb_next  = {1'b0, mb_reg[MULB_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
        end

        case (st_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next   = x_in;
                    acc_next = HALF;
                    mc_next  = ACC_W'(fast_reg);
                    mb_next  = MULB_W'(fast_c_reg);
                    cnt_next = CNT_W'(COEFF_BITS);
                    st_next  = ST_F1;
                end
            end
            ST_F1: begin
                if (mul_last) begin
                    mc_next  = ACC_W'(x_reg);
                    mb_next  = MULB_W'(ONE - {1'b0, fast_c_reg});
                    cnt_next = CNT_W'(COEFF_BITS + 1);
                    st_next  = ST_F2;
                end
            end
            ST_F2: begin
                if (mul_last) begin
                    fast_next = sm_res;
                    acc_next  = HALF;
                    mc_next   = ACC_W'(slow_reg);
                    mb_next   = MULB_W'(slow_c_reg);
                    cnt_next  = CNT_W'(COEFF_BITS);
                    st_next   = ST_S1;
                end
            end
            ST_S1: begin
                if (mul_last) begin
                    mc_next  = ACC_W'(x_reg);
                    mb_next  = MULB_W'(ONE - {1'b0, slow_c_reg});
                    cnt_next = CNT_W'(COEFF_BITS + 1);
                    st_next  = ST_S2;
                end
            end
            ST_S2: begin
                if (mul_last) begin
                    slow_next = sm_res;
                    d_next    = (fast_reg > sm_res) ? fast_reg - sm_res : '0;
                    // knee product bulge_ratio * full_scale
                    acc_next  = '0;
                    mc_next   = ACC_W'(full_reg);
                    mb_next   = MULB_W'(bulge_reg);
                    cnt_next  = CNT_W'(REG_W);
                    st_next   = ST_SC;
                end
            end
            ST_SC: begin
                if (mul_last) begin
                    s_next = acc_step[31:8];
                    if (d_reg == '0 || d_reg > p_val) begin
                        // curve is zero: go straight to the level average
                        x_next   = '0;
                        acc_next = HALF;
                        mc_next  = ACC_W'(lavg_reg);
                        mb_next  = MULB_W'(level_c_reg);
                        cnt_next = CNT_W'(COEFF_BITS);
                        st_next  = ST_L1;
                    end else begin
                        div_start = 1'b1;
                        div_dvd   = DVD_W'({d_reg, 24'h0});
                        div_dvs   = DVS_W'({1'b0, d_reg} + {1'b0, acc_step[31:8]});
                        st_next   = ST_DA;
                    end
                end
            end
            ST_DA: begin
                if (div_done) begin
                    a_next    = div_q[MULB_W-1:0];
                    div_start = 1'b1;
                    div_dvd   = DVD_W'({d_reg, 24'h0});
                    div_dvs   = DVS_W'({1'b0, s_reg} + {1'b0, p_val});
                    st_next   = ST_DB;
                end
            end
            ST_DB: begin
                if (div_done) begin
                    acc_next = '0;
                    mc_next  = ACC_W'(m_val);
                    mb_next  = ab_diff;
                    cnt_next = CNT_W'(MULB_W);
                    st_next  = ST_PM;
                end
            end
            ST_PM: begin
                if (mul_last) begin
                    div_start = 1'b1;
                    div_dvd   = acc_step;
                    div_dvs   = {full_reg, 16'h0000};
                    st_next   = ST_DC;
                end
            end
            ST_DC: begin
                if (div_done) begin
                    x_next   = div_q[AVG_W-1:0];
                    acc_next = HALF;
                    mc_next  = ACC_W'(lavg_reg);
                    mb_next  = MULB_W'(level_c_reg);
                    cnt_next = CNT_W'(COEFF_BITS);
                    st_next  = ST_L1;
                end
            end
            ST_L1: begin
                if (mul_last) begin
                    mc_next  = ACC_W'(x_reg);
                    mb_next  = MULB_W'(ONE - {1'b0, level_c_reg});
                    cnt_next = CNT_W'(COEFF_BITS + 1);
                    st_next  = ST_L2;
                end
            end
            ST_L2: begin
                if (mul_last) begin
                    lavg_next = sm_res;
                    st_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                // hand the word over once the output register is free
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    case (phase_reg)
                        PH_IDLE: begin
                            if (lvl > on_thr_reg) begin
                                phase_next = PH_ONSET;
                                mdata_next = {4'h0, 1'b0, 1'b1, PH_ONSET, lvl};
                            end else begin
                                mdata_next = {4'h0, 1'b0, 1'b0, PH_IDLE, lvl};
                            end
                        end
                        PH_ONSET: begin
                            phase_next = PH_ON;
                            mdata_next = {4'h0, 1'b0, 1'b0, PH_ON, lvl};
                        end
                        PH_ON: begin
                            if (lvl < off_thr_reg) begin
                                phase_next = PH_RELEASE;
                                mdata_next = {4'h0, 1'b1, 1'b0, PH_RELEASE, lvl};
                            end else begin
                                mdata_next = {4'h0, 1'b0, 1'b0, PH_ON, lvl};
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                            mdata_next = {4'h0, 1'b0, 1'b0, PH_IDLE, lvl};
                        end
                    endcase
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            fast_reg  <= '0;
            slow_reg  <= '0;
            lavg_reg  <= '0;
            phase_reg <= PH_IDLE;
            mv_reg    <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            st_reg    <= st_next;
            fast_reg  <= fast_next;
            slow_reg  <= slow_next;
            lavg_reg  <= lavg_next;
            phase_reg <= phase_next;
            mv_reg    <= mv_next;
            cnt_reg   <= cnt_next;
        end
        x_reg     <= x_next;
        d_reg     <= d_next;
        s_reg     <= s_next;
        a_reg     <= a_next;
        acc_reg   <= acc_next;
        mc_reg    <= mc_next;
        mb_reg    <= mb_next;
        mdata_reg <= mdata_next;
    end

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;

`ifndef SYNTHESIS
    // onset flag only comes with the new-onset state
    a_onset_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[18] |-> m_tdata[17:16] == PH_ONSET)
        else $error("onset flag without new-onset state");

    // release flag only comes with the new-release state
    a_release_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[19] |-> m_tdata[17:16] == PH_RELEASE)
        else $error("release flag without new-release state");

    // divider finishes only while the sequencer waits on it
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (st_reg == ST_DA || st_reg == ST_DB || st_reg == ST_DC))
        else $error("divider done outside a divide wait");

    // a word is produced only from the output state
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(st_reg) == ST_OUT)
        else $error("result word raised outside the output state");
`endif

endmodule

// ===== dv/tb_impulse_onset_detector.sv =====
// Testbench for impulse_onset_detector: random and directed sample words,
// a predictor of the averages, bulge curve and detector phase.
// Depends on iod_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_impulse_onset_detector;
    import iod_pkg::*;

    localparam int TIMEOUT_CYCLES = 4_000_000;
    localparam int DRAIN_CYCLES   = 400;

    // packed from the top bit down: release_res, onset, det_state, level
    typedef struct packed {
        logic        release_res;
        logic        onset;
        logic [1:0]  det_state;
        logic [15:0] level;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    impulse_onset_detector u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // predictor copy of the registers and state
    logic [63:0] r_floor, r_fast, r_slow, r_level, r_on, r_off, r_bulge, r_full;
    logic [63:0] fast_avg, slow_avg, level_avg;
    logic [1:0]  det_phase;

    logic [15:0] sample_q[$];
    result_t     expected_q[$];
    int          errors = 0;
    int          cycle = 0;
    bit          hold_rx = 1'b0;
    bit          stim_done = 1'b0;

    initial forever #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > TIMEOUT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [63:0] sat24(input logic [63:0] v);
        return (v > 64'hFFFFFF) ? 64'hFFFFFF : v;
    endfunction

    function automatic logic [63:0] ema(input logic [63:0] acc, input logic [63:0] x,
                                        input logic [63:0] c);
        return sat24((acc * c + x * (64'd65536 - c) + 64'd32768) >> 16);
    endfunction

    function automatic logic [63:0] bulge_curve(input logic [63:0] d);
        logic [63:0] p, s, a, b;
        p = r_full << 8;
        s = (r_bulge * r_full) >> 8;
        if (d == 0 || d > p) return 0;
        a = (d << 24) / (d + s);
        b = (d << 24) / (s + p);
        return ((a - b) * (20 * s + 2 * p)) / (p << 8);
    endfunction

    // advance the predictor by one sample, queue the expected result word
    task automatic predict_sample(input logic [15:0] smp);
        logic [63:0] x, d, lvl;
        result_t r;
        x = (smp > r_floor) ? smp - r_floor : 0;
        x = sat24(x << 8);
        fast_avg  = ema(fast_avg, x, r_fast);
        slow_avg  = ema(slow_avg, x, r_slow);
        d = (fast_avg > slow_avg) ? fast_avg - slow_avg : 0;
        level_avg = ema(level_avg, bulge_curve(d), r_level);
        lvl = level_avg >> 4;
        if (lvl > 64'hFFFF) lvl = 64'hFFFF;
        r.onset = 1'b0;
        r.release_res = 1'b0;
        case (det_phase)
            PH_IDLE: if (lvl > r_on) begin
                det_phase = PH_ONSET;
                r.onset = 1'b1;
            end
            PH_ONSET: det_phase = PH_ON;
            PH_ON: if (lvl < r_off) begin
                det_phase = PH_RELEASE;
                r.release_res = 1'b1;
            end
            default: det_phase = PH_IDLE;
        endcase
        r.level = lvl[15:0];
        r.det_state = det_phase;
        expected_q.push_back(r);
    endtask

    // driver: one sample word per handshake, random gap before each
    int tx_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_sample(s_tdata);
                tx_gap <= $urandom_range(0, 14) * $urandom_range(0, 1);
                if (sample_q.size() > 0 && tx_gap == 0) begin
                    s_tdata <= sample_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end else if (!s_tvalid) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                end else if (sample_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= sample_q.pop_front();
                end
            end
        end
    end

    // monitor: random backpressure, compare each result word
    int rx_gap = 0;
    always @(posedge aclk) begin
        result_t got, exp_r;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[19:0]);
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, m_tdata);
                    errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r || m_tdata[23:20] !== 4'd0) begin
                        $display("%0t: expected lvl %h st %0d on %b rel %b, got %h",
                                 $time, exp_r.level, exp_r.det_state, exp_r.onset,
                                 exp_r.release_res, m_tdata);
                        errors++;
                    end
                end
                rx_gap <= $urandom_range(0, 14) * $urandom_range(0, 1);
                m_tready <= 1'b0;
            end else if (hold_rx) begin
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic wait_idle();
        while (sample_q.size() > 0 || s_tvalid || expected_q.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            IDX_FLOOR:   r_floor = val;
            IDX_FAST:    r_fast  = val;
            IDX_SLOW:    r_slow  = val;
            IDX_LEVEL:   r_level = val;
            IDX_ON_THR:  r_on    = val;
            IDX_OFF_THR: r_off   = val;
            IDX_BULGE:   r_bulge = val;
            IDX_FULL:    r_full  = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // bursts of quiet then loud samples drive onsets and releases
    task automatic push_random(input int n, input int peak);
        int k;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0:       sample_q.push_back(16'($urandom));
                1, 2, 3: sample_q.push_back(16'($urandom_range(0, peak)));
                default: sample_q.push_back(((k / 12) % 2) ? 16'($urandom_range(peak / 2, peak))
                                                            : 16'($urandom_range(0, 40)));
            endcase
        end
    endtask

    initial begin
        int ph;
        r_floor = 0; r_fast = RST_FAST; r_slow = RST_SLOW; r_level = RST_LEVEL;
        r_on = RST_ON_THR; r_off = RST_OFF_THR; r_bulge = RST_BULGE; r_full = RST_FULL;
        fast_avg = 0; slow_avg = 0; level_avg = 0; det_phase = PH_IDLE;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, zero, step up and down through the curve
        sample_q.push_back(16'h0000);
        sample_q.push_back(16'hFFFF);
        sample_q.push_back(16'hAAAA);
        sample_q.push_back(16'h5555);
        repeat (4) sample_q.push_back(16'd0);
        repeat (6) sample_q.push_back(16'd3000);
        repeat (8) sample_q.push_back(16'd0);
        wait_idle();

        // long receiver stall while the sender keeps offering words
        hold_rx = 1'b1;
        push_random(40, 4000);
        repeat (3000) @(posedge aclk);
        hold_rx = 1'b0;
        wait_idle();

        // unknown index is ignored; floor raised above the quiet samples
        write_reg(4'd12, 16'hFFFF);
        write_reg(IDX_FLOOR, 16'd2000);
        push_random(100, 6000);
        wait_idle();

        for (ph = 0; ph < 6; ph++) begin
            write_reg(IDX_FLOOR,   ph == 5 ? 16'hFFFF : 16'($urandom_range(0, 200)));
            write_reg(IDX_FAST,    ph == 1 ? 16'h0000 : (ph == 2 ? 16'hFFFF
                                                        : 16'($urandom_range(30000, 60000))));
            write_reg(IDX_SLOW,    ph == 1 ? 16'hFFFF : (ph == 2 ? 16'h0000
                                                        : 16'($urandom_range(50000, 65535))));
            write_reg(IDX_LEVEL,   ph == 3 ? 16'h0000 : (ph == 4 ? 16'hFFFF
                                                        : 16'($urandom_range(40000, 65000))));
            write_reg(IDX_ON_THR,  ph == 4 ? 16'hFFFF : (ph == 3 ? 16'h0000
                                                        : 16'($urandom_range(5, 300))));
            write_reg(IDX_OFF_THR, ph == 4 ? 16'h0000 : (ph == 3 ? 16'hFFFF
                                                        : 16'($urandom_range(0, 40))));
            write_reg(IDX_BULGE,   ph == 1 ? 16'h0000 : (ph == 2 ? 16'hFFFF
                                                        : 16'($urandom)));
            write_reg(IDX_FULL,    ph == 1 ? 16'd1 : (ph == 2 ? 16'hFFFF
                                                        : 16'($urandom_range(500, 20000))));
            push_random(230, ph == 2 ? 65535 : 10000);
            wait_idle();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/iod_pkg.sv
rtl/iod_divider.sv
rtl/impulse_onset_detector.sv
dv/tb_impulse_onset_detector.sv
